// ===== rtl/core/nbc_pkg.sv =====
// ---------------------------------------------------------------------------
// nbc_pkg
// Shared constants, datapath operation codes and controller/datapath structs
// for the natural breaks classifier.
// ---------------------------------------------------------------------------
package nbc_pkg;

   localparam int MAX_VALUES    = 256;
   localparam int MAX_CLASSES   = 8;
   localparam int VALUE_BITS    = 16;
   localparam int FRAC_BITS     = 16;

   localparam int ADDR_BITS     = $clog2(MAX_VALUES);
   localparam int CNT_BITS      = ADDR_BITS + 1;
   localparam int CLS_BITS      = $clog2(MAX_CLASSES);
   localparam int KCFG_BITS     = 4;
   localparam int COST_BITS     = 64;
   localparam int S1_BITS       = VALUE_BITS + ADDR_BITS;
   localparam int SQ_BITS       = 2 * VALUE_BITS;
   localparam int S2_BITS       = SQ_BITS + ADDR_BITS;
   localparam int P2_BITS       = 2 * S1_BITS;
   localparam int DEV_BITS      = S2_BITS + CNT_BITS;
   localparam int DIV_BITS      = 64;
   localparam int DIV_CNT_BITS  = $clog2(DIV_BITS + 1);
   localparam int MEM_DEPTH     = MAX_VALUES * MAX_CLASSES;
   localparam int MEM_ADDR_BITS = ADDR_BITS + CLS_BITS;

   localparam int CSR_ADDR_BITS = 3;
   localparam int CSR_DATA_BITS = 32;
   localparam logic [KCFG_BITS-1:0] CLASS_COUNT_RESET = 4'd5;
   localparam logic [CSR_ADDR_BITS-3:0] REG_CLASS_COUNT = '0;

   localparam logic [COST_BITS-1:0] COST_INF = {COST_BITS{1'b1}};

   typedef enum logic [4:0] {
      OP_NONE,
      OP_LOAD,
      OP_INS_RD,
      OP_INS_CMP,
      OP_RUN,
      OP_ROW1,
      OP_ROW_INIT,
      OP_M_RD,
      OP_M_SQ,
      OP_M_SUM,
      OP_M_PROD,
      OP_M_DIV,
      OP_M_WAIT,
      OP_C_RD,
      OP_C_CMP,
      OP_M_NEXT,
      OP_ROW_WR,
      OP_TB_LRD,
      OP_TB_LST,
      OP_TB_SRD,
      OP_TB_SPL,
      OP_TB_VAL,
      OP_OUT
   } dp_op_type;

   typedef struct packed {
      dp_op_type op;
      logic      idle;
      logic      out_valid;
   } ctl_cmd_type;

   typedef struct packed {
      logic full;
      logic last;
      logic few;
      logic single;
      logic shift;
      logic div_done;
      logic cloop;
      logic c_last;
      logic m_last;
      logic col_last;
      logic row_last;
      logic k_one;
      logic tb_end;
      logic out_last;
   } dp_status_type;

endpackage

// ===== rtl/core/nbc_div.sv =====
// ---------------------------------------------------------------------------
// nbc_div
// Restoring divider, one quotient bit per cycle, for the range deviation
// divided by the range width.
// ---------------------------------------------------------------------------
module nbc_div (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   input  logic [nbc_pkg::DIV_BITS-1:0]  num,
   input  logic [nbc_pkg::CNT_BITS-1:0]  den,
   output logic                          done,
   output logic [nbc_pkg::DIV_BITS-1:0]  quo
);

   logic [nbc_pkg::DIV_BITS-1:0]     q_ff, q_in;
   logic [nbc_pkg::CNT_BITS-1:0]     rem_ff, rem_in;
   logic [nbc_pkg::CNT_BITS-1:0]     den_ff;
   logic [nbc_pkg::DIV_CNT_BITS-1:0] cnt_ff, cnt_in;
   logic                             done_ff, done_in;
   logic [nbc_pkg::CNT_BITS:0]       trial;
   logic                             ge;

   assign trial = {rem_ff, q_ff[nbc_pkg::DIV_BITS-1]};
   assign ge    = trial >= {1'b0, den_ff};

   always_comb begin
      q_in    = q_ff;
      rem_in  = rem_ff;
      cnt_in  = cnt_ff;
      done_in = 1'b0;
      if (start) begin
         q_in   = num;
         rem_in = '0;
         cnt_in = nbc_pkg::DIV_CNT_BITS'(nbc_pkg::DIV_BITS);
      end else if (cnt_ff != '0) begin
         q_in   = {q_ff[nbc_pkg::DIV_BITS-2:0], ge};
         rem_in = ge ? nbc_pkg::CNT_BITS'(trial - {1'b0, den_ff})
                     : nbc_pkg::CNT_BITS'(trial);
         cnt_in = cnt_ff - 1'b1;
         done_in = (cnt_ff == nbc_pkg::DIV_CNT_BITS'(1));
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff  <= '0;
         done_ff <= 1'b0;
      end else begin
         cnt_ff  <= cnt_in;
         done_ff <= done_in;
      end
      q_ff   <= q_in;
      rem_ff <= rem_in;
      if (start) begin
         den_ff <= den;
      end
   end

   assign done = done_ff;
   assign quo  = q_ff;

endmodule

// ===== rtl/core/nbc_ctrl.sv =====
// ---------------------------------------------------------------------------
// nbc_ctrl
// Sequencer for loading, the dynamic program, traceback and break output.
// ---------------------------------------------------------------------------
module nbc_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   input  logic                   rsp_stall,
   input  nbc_pkg::dp_status_type status,
   output nbc_pkg::ctl_cmd_type   cmd
);

   typedef enum logic [4:0] {
      S_IDLE,
      S_INS_RD,
      S_INS_CMP,
      S_RUN,
      S_ROW1,
      S_ROW_INIT,
      S_M_RD,
      S_M_SQ,
      S_M_SUM,
      S_M_PROD,
      S_M_DIV,
      S_M_WAIT,
      S_C_RD,
      S_C_CMP,
      S_M_NEXT,
      S_ROW_WR,
      S_TB_LRD,
      S_TB_LST,
      S_TB_SRD,
      S_TB_SPL,
      S_TB_VAL,
      S_OUT
   } state_type;

   state_type state_ff, state_in;

   always_comb begin
      state_in      = state_ff;
      cmd.op        = nbc_pkg::OP_NONE;
      cmd.idle      = 1'b0;
      cmd.out_valid = 1'b0;
      case (state_ff)
         S_IDLE: begin
            cmd.idle = 1'b1;
            if (req_valid) begin
               cmd.op   = nbc_pkg::OP_LOAD;
               state_in = S_INS_RD;
            end
         end
         S_INS_RD: begin
            cmd.op = nbc_pkg::OP_INS_RD;
            if (status.full) begin
               state_in = status.last ? S_RUN : S_IDLE;
            end else begin
               state_in = S_INS_CMP;
            end
         end
         S_INS_CMP: begin
            cmd.op = nbc_pkg::OP_INS_CMP;
            if (!status.shift) begin
               state_in = status.last ? S_RUN : S_IDLE;
            end
         end
         S_RUN: begin
            cmd.op = nbc_pkg::OP_RUN;
            if (status.few) begin
               state_in = S_OUT;
            end else if (status.single) begin
               state_in = S_TB_LRD;
            end else begin
               state_in = S_ROW1;
            end
         end
         S_ROW1: begin
            cmd.op = nbc_pkg::OP_ROW1;
            if (status.col_last) begin
               state_in = S_ROW_INIT;
            end
         end
         S_ROW_INIT: begin
            cmd.op   = nbc_pkg::OP_ROW_INIT;
            state_in = S_M_RD;
         end
         S_M_RD: begin
            cmd.op   = nbc_pkg::OP_M_RD;
            state_in = S_M_SQ;
         end
         S_M_SQ: begin
            cmd.op   = nbc_pkg::OP_M_SQ;
            state_in = S_M_SUM;
         end
         S_M_SUM: begin
            cmd.op   = nbc_pkg::OP_M_SUM;
            state_in = S_M_PROD;
         end
         S_M_PROD: begin
            cmd.op   = nbc_pkg::OP_M_PROD;
            state_in = S_M_DIV;
         end
         S_M_DIV: begin
            cmd.op   = nbc_pkg::OP_M_DIV;
            state_in = S_M_WAIT;
         end
         S_M_WAIT: begin
            cmd.op = nbc_pkg::OP_M_WAIT;
            if (status.div_done) begin
               state_in = status.cloop ? S_C_RD : S_M_NEXT;
            end
         end
         S_C_RD: begin
            cmd.op   = nbc_pkg::OP_C_RD;
            state_in = S_C_CMP;
         end
         S_C_CMP: begin
            cmd.op   = nbc_pkg::OP_C_CMP;
            state_in = status.c_last ? S_M_NEXT : S_C_RD;
         end
         S_M_NEXT: begin
            cmd.op   = nbc_pkg::OP_M_NEXT;
            state_in = status.m_last ? S_ROW_WR : S_M_RD;
         end
         S_ROW_WR: begin
            cmd.op = nbc_pkg::OP_ROW_WR;
            if (status.col_last) begin
               state_in = status.row_last ? S_TB_LRD : S_ROW_INIT;
            end
         end
         S_TB_LRD: begin
            cmd.op   = nbc_pkg::OP_TB_LRD;
            state_in = S_TB_LST;
         end
         S_TB_LST: begin
            cmd.op   = nbc_pkg::OP_TB_LST;
            state_in = status.k_one ? S_OUT : S_TB_SRD;
         end
         S_TB_SRD: begin
            cmd.op   = nbc_pkg::OP_TB_SRD;
            state_in = S_TB_SPL;
         end
         S_TB_SPL: begin
            cmd.op   = nbc_pkg::OP_TB_SPL;
            state_in = S_TB_VAL;
         end
         S_TB_VAL: begin
            cmd.op   = nbc_pkg::OP_TB_VAL;
            state_in = status.tb_end ? S_OUT : S_TB_SRD;
         end
         S_OUT: begin
            cmd.out_valid = 1'b1;
            if (!rsp_stall) begin
               cmd.op = nbc_pkg::OP_OUT;
               if (status.out_last) begin
                  state_in = S_IDLE;
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

// ===== rtl/core/nbc_dp.sv =====
// ---------------------------------------------------------------------------
// nbc_dp
// Datapath: sorted sample store, range sums, cost and split tables,
// per-row candidate registers, traceback and break registers.
// ---------------------------------------------------------------------------
module nbc_dp (
   input  logic                             clock,
   input  logic                             reset,
   input  nbc_pkg::ctl_cmd_type             cmd,
   input  logic [nbc_pkg::VALUE_BITS-1:0]   sample_value,
   input  logic                             is_last,
   input  logic [nbc_pkg::KCFG_BITS-1:0]    cfg_k,
   output nbc_pkg::dp_status_type           status,
   output logic [nbc_pkg::VALUE_BITS-1:0]   out_break,
   output logic [nbc_pkg::CLS_BITS-1:0]     out_class,
   output logic                             out_too_few
);

   localparam int AB = nbc_pkg::ADDR_BITS;
   localparam int CB = nbc_pkg::CNT_BITS;
   localparam int LB = nbc_pkg::CLS_BITS;
   localparam int VB = nbc_pkg::VALUE_BITS;
   localparam int KB = nbc_pkg::KCFG_BITS;
   localparam int XB = nbc_pkg::COST_BITS;

   // storage
   logic [VB-1:0] sorted_mem [nbc_pkg::MAX_VALUES];
   logic [XB-1:0] best_mem   [nbc_pkg::MEM_DEPTH];
   logic [CB-1:0] split_mem  [nbc_pkg::MEM_DEPTH];
   logic [VB-1:0] sorted_rd_ff;
   logic [XB-1:0] best_rd_ff;
   logic [CB-1:0] split_rd_ff;

   logic [CB-1:0] count_ff, pos_ff, n_ff, r_ff, m_ff, d_ff;
   logic [VB-1:0] v_ff, sv_ff;
   logic          last_ff, tf_ff;
   logic [KB-1:0] k_ff;
   logic [LB-1:0] ci_ff;
   logic [nbc_pkg::S1_BITS-1:0]  s1_ff;
   logic [nbc_pkg::S2_BITS-1:0]  s2_ff;
   logic [nbc_pkg::SQ_BITS-1:0]  sq_ff;
   logic [nbc_pkg::DEV_BITS-1:0] p1_ff;
   logic [nbc_pkg::P2_BITS-1:0]  p2_ff;
   logic [XB-1:0] ssd_ff;
   logic [XB-1:0] cur_cost_ff  [nbc_pkg::MAX_CLASSES];
   logic [CB-1:0] cur_split_ff [nbc_pkg::MAX_CLASSES];
   logic [VB-1:0] brk_ff       [nbc_pkg::MAX_CLASSES];

   logic [KB-1:0] keff;
   logic [LB-1:0] km1;
   logic [AB-1:0] srt_raddr;
   logic          mem_we;
   logic [nbc_pkg::MEM_ADDR_BITS-1:0] mem_waddr;
   logic [XB-1:0] best_wdata;
   logic [CB-1:0] split_wdata;
   logic [XB:0]   cand_sum;
   logic [XB-1:0] cand;
   logic [nbc_pkg::DEV_BITS-1:0] dev;
   logic          div_done;
   logic [nbc_pkg::DIV_BITS-1:0] div_quo;
   logic          s_ge2;

   assign keff = (cfg_k == '0) ? KB'(1)
               : ((cfg_k > KB'(nbc_pkg::MAX_CLASSES)) ? KB'(nbc_pkg::MAX_CLASSES) : cfg_k);
   assign km1   = LB'(k_ff - KB'(1));
   assign s_ge2 = split_rd_ff >= CB'(2);

   assign dev = p1_ff - nbc_pkg::DEV_BITS'(p2_ff);

   nbc_div u_div (
      .clock (clock),
      .reset (reset),
      .start (cmd.op == nbc_pkg::OP_M_DIV),
      .num   (nbc_pkg::DIV_BITS'(dev) << nbc_pkg::FRAC_BITS),
      .den   (m_ff),
      .done  (div_done),
      .quo   (div_quo)
   );

   // saturating candidate cost
   assign cand_sum = {1'b0, ssd_ff} + {1'b0, best_rd_ff};
   assign cand     = cand_sum[XB] ? nbc_pkg::COST_INF : cand_sum[XB-1:0];

   always_comb begin
      case (cmd.op)
         nbc_pkg::OP_INS_RD:  srt_raddr = AB'(pos_ff - CB'(1));
         nbc_pkg::OP_INS_CMP: srt_raddr = AB'(pos_ff - CB'(2));
         nbc_pkg::OP_M_RD:    srt_raddr = AB'(d_ff - CB'(1));
         nbc_pkg::OP_TB_LRD:  srt_raddr = AB'(n_ff - CB'(1));
         nbc_pkg::OP_TB_SPL:  srt_raddr = s_ge2 ? AB'(split_rd_ff - CB'(2)) : '0;
         default:             srt_raddr = '0;
      endcase
   end

   always_comb begin
      mem_we      = 1'b0;
      mem_waddr   = {AB'(r_ff - CB'(1)), ci_ff};
      best_wdata  = cur_cost_ff[ci_ff];
      split_wdata = cur_split_ff[ci_ff];
      case (cmd.op)
         nbc_pkg::OP_ROW1: begin
            mem_we      = 1'b1;
            mem_waddr   = {AB'(0), ci_ff};
            best_wdata  = '0;
            split_wdata = CB'(1);
         end
         nbc_pkg::OP_ROW_WR: begin
            mem_we = 1'b1;
            if (ci_ff == '0) begin
               best_wdata  = ssd_ff;
               split_wdata = CB'(1);
            end
         end
         default: begin
            mem_we = 1'b0;
         end
      endcase
   end

   // memories
   always_ff @(posedge clock) begin
      if (cmd.op == nbc_pkg::OP_INS_CMP) begin
         sorted_mem[AB'(pos_ff)] <= status.shift ? sorted_rd_ff : v_ff;
      end
      sorted_rd_ff <= sorted_mem[srt_raddr];
      if (mem_we) begin
         best_mem[mem_waddr]  <= best_wdata;
         split_mem[mem_waddr] <= split_wdata;
      end
      best_rd_ff  <= best_mem[{AB'(d_ff - CB'(2)), LB'(ci_ff - LB'(1))}];
      split_rd_ff <= split_mem[{AB'(r_ff - CB'(1)), ci_ff}];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         case (cmd.op)
            nbc_pkg::OP_LOAD: begin
               v_ff    <= sample_value;
               last_ff <= is_last;
               pos_ff  <= count_ff;
            end
            nbc_pkg::OP_INS_CMP: begin
               if (status.shift) begin
                  pos_ff <= pos_ff - CB'(1);
               end else begin
                  count_ff <= count_ff + CB'(1);
               end
            end
            nbc_pkg::OP_RUN: begin
               n_ff     <= count_ff;
               k_ff     <= keff;
               tf_ff    <= status.few;
               count_ff <= '0;
               ci_ff    <= '0;
            end
            nbc_pkg::OP_ROW1: begin
               ci_ff <= ci_ff + LB'(1);
               r_ff  <= CB'(2);
            end
            nbc_pkg::OP_ROW_INIT: begin
               s1_ff <= '0;
               s2_ff <= '0;
               m_ff  <= CB'(1);
               d_ff  <= r_ff;
               for (int i = 0; i < nbc_pkg::MAX_CLASSES; i++) begin
                  cur_cost_ff[i]  <= nbc_pkg::COST_INF;
                  cur_split_ff[i] <= CB'(1);
               end
            end
            nbc_pkg::OP_M_SQ: begin
               sv_ff <= sorted_rd_ff;
               sq_ff <= sorted_rd_ff * sorted_rd_ff;
            end
            nbc_pkg::OP_M_SUM: begin
               s1_ff <= s1_ff + nbc_pkg::S1_BITS'(sv_ff);
               s2_ff <= s2_ff + nbc_pkg::S2_BITS'(sq_ff);
            end
            nbc_pkg::OP_M_PROD: begin
               p1_ff <= nbc_pkg::DEV_BITS'(s2_ff) * nbc_pkg::DEV_BITS'(m_ff);
               p2_ff <= s1_ff * s1_ff;
            end
            nbc_pkg::OP_M_WAIT: begin
               if (div_done) begin
                  ssd_ff <= div_quo;
                  ci_ff  <= LB'(1);
               end
            end
            nbc_pkg::OP_C_CMP: begin
               if (cand <= cur_cost_ff[ci_ff]) begin
                  cur_cost_ff[ci_ff]  <= cand;
                  cur_split_ff[ci_ff] <= d_ff;
               end
               ci_ff <= ci_ff + LB'(1);
            end
            nbc_pkg::OP_M_NEXT: begin
               ci_ff <= '0;
               if (!status.m_last) begin
                  m_ff <= m_ff + CB'(1);
                  d_ff <= d_ff - CB'(1);
               end
            end
            nbc_pkg::OP_ROW_WR: begin
               ci_ff <= ci_ff + LB'(1);
               if (status.col_last && !status.row_last) begin
                  r_ff <= r_ff + CB'(1);
               end
            end
            nbc_pkg::OP_TB_LRD: begin
               r_ff  <= n_ff;
               ci_ff <= km1;
            end
            nbc_pkg::OP_TB_LST: begin
               brk_ff[km1] <= sorted_rd_ff;
            end
            nbc_pkg::OP_TB_SPL: begin
               r_ff <= s_ge2 ? (split_rd_ff - CB'(1)) : CB'(1);
            end
            nbc_pkg::OP_TB_VAL: begin
               brk_ff[LB'(ci_ff - LB'(1))] <= sorted_rd_ff;
               ci_ff <= ci_ff - LB'(1);
            end
            nbc_pkg::OP_OUT: begin
               ci_ff <= ci_ff + LB'(1);
            end
            default: begin
               count_ff <= count_ff;
            end
         endcase
      end
   end

   always_comb begin
      status.full     = count_ff >= CB'(nbc_pkg::MAX_VALUES);
      status.last     = last_ff;
      status.few      = count_ff < CB'(keff);
      status.single   = count_ff == CB'(1);
      status.shift    = (pos_ff != '0) && (sorted_rd_ff > v_ff);
      status.div_done = div_done;
      status.cloop    = (d_ff >= CB'(2)) && (k_ff >= KB'(2));
      status.c_last   = ci_ff == km1;
      status.m_last   = d_ff == CB'(1);
      status.col_last = ci_ff == LB'(nbc_pkg::MAX_CLASSES - 1);
      status.row_last = r_ff == n_ff;
      status.k_one    = k_ff == KB'(1);
      status.tb_end   = ci_ff == LB'(1);
      status.out_last = tf_ff || (ci_ff == km1);
   end

   assign out_break   = tf_ff ? '0 : brk_ff[ci_ff];
   assign out_class   = tf_ff ? '0 : ci_ff;
   assign out_too_few = tf_ff;

   a_cmp_class_nonzero: assert property (@(posedge clock) disable iff (reset)
      cmd.op == nbc_pkg::OP_C_CMP |-> ci_ff != '0)
      else $error("candidate compare at class column zero");

   a_run_empties_store: assert property (@(posedge clock) disable iff (reset)
      cmd.op == nbc_pkg::OP_RUN |=> count_ff == '0)
      else $error("store not emptied at run start");

   a_insert_counts: assert property (@(posedge clock) disable iff (reset)
      (cmd.op == nbc_pkg::OP_INS_CMP && !status.shift)
      |=> count_ff == $past(count_ff) + CB'(1))
      else $error("insertion did not bump the count");

   a_range_bounds: assert property (@(posedge clock) disable iff (reset)
      cmd.op == nbc_pkg::OP_M_SUM
      |-> ({1'b0, d_ff} + {1'b0, m_ff}) == ({1'b0, r_ff} + (CB + 1)'(1)))
      else $error("range start and width disagree with row");

endmodule

// ===== rtl/core/natural_breaks_classifier.sv =====
// ---------------------------------------------------------------------------
// natural_breaks_classifier
// Jenks natural-breaks classifier: sorted sample store plus a sequenced
// dynamic program that emits one upper break value per class.
// ---------------------------------------------------------------------------
// samples insert in sorted order, larger entries shifting up one place at a time
// a last sample runs the program: about n*n/2 ranges, each through the 64-bit range
//   divider and the cost compares; traceback then walks the split table
// k results go out, one a cycle while rsp_stall is low (one too-few item if n < k)
// one item in flight; after acceptance input stalls to insertion end or the last result
// reset clears the sample count and loads class_count 5; tables need no clearing
module natural_breaks_classifier (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic [nbc_pkg::VALUE_BITS-1:0]      req_sample_value,
   input  logic                                req_is_last,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic [nbc_pkg::VALUE_BITS-1:0]      rsp_break_value,
   output logic [nbc_pkg::CLS_BITS-1:0]        rsp_class_number,
   output logic                                rsp_too_few,
   output logic                                rsp_last_break,
   input  logic                                psel,
   input  logic                                penable,
   input  logic                                pwrite,
   input  logic [nbc_pkg::CSR_ADDR_BITS-1:0]   paddr,
   input  logic [nbc_pkg::CSR_DATA_BITS-1:0]   pwdata,
   output logic [nbc_pkg::CSR_DATA_BITS-1:0]   prdata,
   output logic                                pready
);

   nbc_pkg::ctl_cmd_type   cmd;
   nbc_pkg::dp_status_type status;
   logic [nbc_pkg::KCFG_BITS-1:0] class_count_ff;
   logic                          hit;

   assign pready = 1'b1;
   assign hit    = paddr[nbc_pkg::CSR_ADDR_BITS-1:2] == nbc_pkg::REG_CLASS_COUNT;

   always_ff @(posedge clock) begin
      if (reset) begin
         class_count_ff <= nbc_pkg::CLASS_COUNT_RESET;
      end else if (psel && penable && pwrite && pready && hit) begin
         class_count_ff <= pwdata[nbc_pkg::KCFG_BITS-1:0];
      end
   end

   assign prdata = hit ? nbc_pkg::CSR_DATA_BITS'(class_count_ff) : '0;

   nbc_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .rsp_stall (rsp_stall),
      .status    (status),
      .cmd       (cmd)
   );

   nbc_dp u_dp (
      .clock        (clock),
      .reset        (reset),
      .cmd          (cmd),
      .sample_value (req_sample_value),
      .is_last      (req_is_last),
      .cfg_k        (class_count_ff),
      .status       (status),
      .out_break    (rsp_break_value),
      .out_class    (rsp_class_number),
      .out_too_few  (rsp_too_few)
   );

   assign req_stall      = !cmd.idle;
   assign rsp_valid      = cmd.out_valid;
   assign rsp_last_break = status.out_last;

endmodule

// ===== dv/tb_natural_breaks_classifier.sv =====
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// tb_natural_breaks_classifier
// Loads sample sets into the classifier and checks every break item it
// returns against a cycle-free predictor of the sorted store and of the
// natural-breaks program. Class count is changed between sets over the
// register port. The request side idles and the response side stalls at random.
// ---------------------------------------------------------------------------
module tb_natural_breaks_classifier;

   localparam logic [nbc_pkg::CSR_ADDR_BITS-1:0] CSR_CLASS_COUNT_ADDR = 3'd0;
   localparam logic [nbc_pkg::CSR_ADDR_BITS-1:0] CSR_UNMAPPED_ADDR    = 3'd4;
   localparam int CYCLE_LIMIT  = 20_000_000;
   localparam int INSERT_SETTLE = nbc_pkg::MAX_VALUES + 40;

   typedef struct {
      logic [nbc_pkg::VALUE_BITS-1:0] brk;
      logic [nbc_pkg::CLS_BITS-1:0]   cls;
      logic                           few;
      logic                           last;
   } break_item_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   logic [nbc_pkg::VALUE_BITS-1:0] req_sample_value = '0;
   logic req_is_last = 1'b0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   logic [nbc_pkg::VALUE_BITS-1:0] rsp_break_value;
   logic [nbc_pkg::CLS_BITS-1:0] rsp_class_number;
   logic rsp_too_few;
   logic rsp_last_break;
   logic psel = 1'b0;
   logic penable = 1'b0;
   logic pwrite = 1'b0;
   logic [nbc_pkg::CSR_ADDR_BITS-1:0] paddr = '0;
   logic [nbc_pkg::CSR_DATA_BITS-1:0] pwdata = '0;
   logic [nbc_pkg::CSR_DATA_BITS-1:0] prdata;
   logic pready;

   // predictor state
   logic [nbc_pkg::VALUE_BITS-1:0] held_values[nbc_pkg::MAX_VALUES];
   int unsigned held_count = 0;
   logic [nbc_pkg::KCFG_BITS-1:0] class_cfg = nbc_pkg::CLASS_COUNT_RESET;
   logic [63:0] min_cost[nbc_pkg::MAX_VALUES][nbc_pkg::MAX_CLASSES];
   int unsigned last_start[nbc_pkg::MAX_VALUES][nbc_pkg::MAX_CLASSES];

   break_item_type expected_breaks[$];
   int unsigned errors = 0;
   int unsigned breaks_seen = 0;
   int unsigned sets_run = 0;
   int unsigned samples_sent = 0;
   int unsigned cycles = 0;
   bit req_quiet = 0;
   bit rsp_quiet = 0;

   natural_breaks_classifier dut (.*);

   initial begin
      forever #6 clock = ~clock;
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("%0t timeout with %0d break items pending", $time,
                  expected_breaks.size());
         $display("TB_ERROR");
         $finish;
      end
   end

   always @(negedge clock) begin
      rsp_stall <= rsp_quiet ? 1'b0 : ($urandom_range(99) < 24);
   end

   // result checker
   always @(posedge clock) begin
      break_item_type e;
      if (!reset && rsp_valid && !rsp_stall) begin
         breaks_seen++;
         if (expected_breaks.size() == 0) begin
            errors++;
            $display("%0t unexpected break item: brk=%0d cls=%0d few=%0b last=%0b", $time,
                     rsp_break_value, rsp_class_number, rsp_too_few, rsp_last_break);
         end else begin
            e = expected_breaks[0];
            expected_breaks.delete(0);
            if (rsp_break_value !== e.brk || rsp_class_number !== e.cls ||
                rsp_too_few !== e.few || rsp_last_break !== e.last) begin
               errors++;
               $display("%0t mismatch: expected brk=%0d cls=%0d few=%0b last=%0b,",
                        $time, e.brk, e.cls, e.few, e.last);
               $display("   actual brk=%0d cls=%0d few=%0b last=%0b", rsp_break_value,
                        rsp_class_number, rsp_too_few, rsp_last_break);
            end
         end
      end
   end

   function automatic logic [63:0] cost_add(logic [63:0] a, logic [63:0] b);
      logic [63:0] s;
      s = a + b;
      return (s < a) ? nbc_pkg::COST_INF : s;
   endfunction

   function automatic void hold_sample(logic [nbc_pkg::VALUE_BITS-1:0] v);
      int unsigned pos;
      pos = held_count;
      if (held_count >= nbc_pkg::MAX_VALUES) return;
      while (pos > 0 && held_values[pos-1] > v) begin
         held_values[pos] = held_values[pos-1];
         pos--;
      end
      held_values[pos] = v;
      held_count++;
   endfunction

   // jenks program over the held samples; rows and classes are 1-based
   function automatic void predict_breaks();
      int unsigned n, k, r, c, m, d, row, s;
      logic [63:0] s1, s2, dev, w, ssd, v, cand;
      logic [nbc_pkg::VALUE_BITS-1:0] brk[nbc_pkg::MAX_CLASSES];
      break_item_type e;
      n = held_count;
      k = class_cfg;
      if (k < 1) k = 1;
      if (k > nbc_pkg::MAX_CLASSES) k = nbc_pkg::MAX_CLASSES;
      held_count = 0;
      sets_run++;
      if (n < k) begin
         e.brk = '0; e.cls = '0; e.few = 1'b1; e.last = 1'b1;
         expected_breaks.push_back(e);
         return;
      end
      for (c = 1; c <= k; c++) begin
         min_cost[0][c-1] = '0;
         last_start[0][c-1] = 1;
         for (r = 2; r <= n; r++) begin
            min_cost[r-1][c-1] = nbc_pkg::COST_INF;
            last_start[r-1][c-1] = 1;
         end
      end
      for (r = 2; r <= n; r++) begin
         s1 = '0; s2 = '0; ssd = '0;
         for (m = 1; m <= r; m++) begin
            d = r - m + 1;
            v = 64'(held_values[d-1]);
            w = 64'(m);
            s1 += v;
            s2 += v * v;
            dev = s2 * w - s1 * s1;
            ssd = ((dev / w) << nbc_pkg::FRAC_BITS)
                + (((dev % w) << nbc_pkg::FRAC_BITS) / w);
            if (d >= 2) begin
               for (c = 2; c <= k; c++) begin
                  cand = cost_add(ssd, min_cost[d-2][c-2]);
                  if (cand <= min_cost[r-1][c-1]) begin
                     min_cost[r-1][c-1] = cand;
                     last_start[r-1][c-1] = d;
                  end
               end
            end
         end
         min_cost[r-1][0] = ssd;
         last_start[r-1][0] = 1;
      end
      brk[k-1] = held_values[n-1];
      row = n;
      for (c = k; c >= 2; c--) begin
         s = last_start[row-1][c-1];
         if (s >= 2) begin
            brk[c-2] = held_values[s-2];
            row = s - 1;
         end else begin
            // split at the first sample: break is the first sample
            brk[c-2] = held_values[0];
            row = 1;
         end
      end
      for (c = 0; c < k; c++) begin
         e.brk = brk[c];
         e.cls = c[nbc_pkg::CLS_BITS-1:0];
         e.few = 1'b0;
         e.last = (c + 1 == k);
         expected_breaks.push_back(e);
      end
   endfunction

   task automatic send_sample(logic [nbc_pkg::VALUE_BITS-1:0] v, logic last_flag);
      int unsigned gap;
      gap = 0;
      if (!req_quiet && $urandom_range(99) < 24) gap = $urandom_range(1, 6);
      repeat (gap) begin
         @(negedge clock);
         req_valid <= 1'b0;
      end
      @(negedge clock);
      req_valid <= 1'b1;
      req_sample_value <= v;
      req_is_last <= last_flag;
      do @(posedge clock); while (req_stall);
      samples_sent++;
      hold_sample(v);
      if (last_flag) predict_breaks();
   endtask

   task automatic idle_sender();
      @(negedge clock);
      req_valid <= 1'b0;
   endtask

   // every expected item out, then room for a pending insertion
   task automatic wait_drained();
      idle_sender();
      while (expected_breaks.size() != 0) @(posedge clock);
      repeat (INSERT_SETTLE) @(posedge clock);
   endtask

   task automatic csr_write(logic [nbc_pkg::CSR_ADDR_BITS-1:0] addr,
                            logic [nbc_pkg::CSR_DATA_BITS-1:0] data);
      wait_drained();
      @(negedge clock);
      psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1; paddr <= addr; pwdata <= data;
      @(negedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      if (addr == CSR_CLASS_COUNT_ADDR) class_cfg = data[nbc_pkg::KCFG_BITS-1:0];
      @(negedge clock);
      psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
   endtask

   function automatic logic [nbc_pkg::VALUE_BITS-1:0] pick_value();
      int unsigned sel;
      sel = $urandom_range(99);
      if (sel < 5) return (sel < 3) ? '1 : '0;
      if (sel < 35) return nbc_pkg::VALUE_BITS'($urandom_range(15));
      return nbc_pkg::VALUE_BITS'($urandom);
   endfunction

   task automatic send_set(int unsigned count);
      for (int unsigned i = 1; i <= count; i++) send_sample(pick_value(), i == count);
   endtask

   task automatic test_directed();
      // default five classes, extreme and alternating values
      send_sample(16'h0000, 0);
      send_sample(16'hFFFF, 0);
      send_sample(16'h5555, 0);
      send_sample(16'hAAAA, 0);
      send_sample(16'h0001, 0);
      send_sample(16'h8000, 1);
      // too few samples for five classes
      send_sample(16'h1234, 0);
      send_sample(16'h4321, 1);
      // zero class count acts as one class, single sample
      csr_write(CSR_CLASS_COUNT_ADDR, 0);
      send_sample(16'h7FFF, 1);
      // above max saturates to eight; equal samples force early splits
      csr_write(CSR_CLASS_COUNT_ADDR, 15);
      for (int i = 0; i < 8; i++) send_sample(16'h0042, i == 7);
      // unmapped register is ignored
      csr_write(CSR_UNMAPPED_ADDR, 2);
      csr_write(CSR_CLASS_COUNT_ADDR, 2);
      send_sample(16'h0003, 0);
      send_sample(16'h0003, 0);
      send_sample(16'hFFFE, 1);
   endtask

   task automatic test_random_sets();
      int unsigned sent;
      int unsigned size;
      sent = 0;
      while (sent < 180) begin
         if ($urandom_range(3) == 0)
            csr_write(CSR_CLASS_COUNT_ADDR, $urandom_range(15));
         // quiet stretch with no idling on either side
         req_quiet = (sent >= 80 && sent < 130);
         rsp_quiet = req_quiet;
         size = ($urandom_range(9) == 0) ? $urandom_range(20, 32) : $urandom_range(1, 12);
         send_set(size);
         sent += size;
         if (sent > 150 && sent < 170) wait_drained();
      end
      req_quiet = 0;
      rsp_quiet = 0;
   endtask

   task automatic test_store_full();
      csr_write(CSR_CLASS_COUNT_ADDR, 8);
      req_quiet = 1;
      for (int i = 0; i < nbc_pkg::MAX_VALUES + 4; i++)
         send_sample(pick_value(), i == nbc_pkg::MAX_VALUES + 3);
      req_quiet = 0;
      csr_write(CSR_CLASS_COUNT_ADDR, 1);
      send_set(5);
   endtask

   initial begin
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      test_directed();
      test_random_sets();
      test_store_full();
      idle_sender();
      while (expected_breaks.size() != 0) @(posedge clock);
      repeat (100) @(posedge clock);
      $display("ran %0d sample sets from %0d samples, %0d break items checked",
               sets_run, samples_sent, breaks_seen);
      $display("class counts 0 to 15, too-few sets, tied samples and a full store covered");
      if (errors == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

endmodule
